>>> rtl/core/slacu_pkg.sv
// ----------------------------------------------------------------------------
// slacu_pkg
// Shared types, codes and constants of the two-axis command unit.
// ----------------------------------------------------------------------------
package slacu_pkg;

  localparam int RATIO_FRAC_BITS_DEF = 16;
  localparam int POS_W               = 32;
  localparam int RATIO_W             = 24;
  localparam int PROD_W              = POS_W + RATIO_W;
  localparam int CFG_INDEX_W         = 3;

  localparam logic signed [POS_W-1:0]   LOW_LIMIT_RST  = -32'sd100000;
  localparam logic signed [POS_W-1:0]   HIGH_LIMIT_RST = 32'sd100000;
  // 1.0 in Q8.16
  localparam logic signed [RATIO_W-1:0] RATIO_RST      = 24'sd65536;

  typedef enum logic [3:0] {
    CMD_REL     = 4'd0,
    CMD_ABS     = 4'd1,
    CMD_WHEEL   = 4'd2,
    CMD_SPEED   = 4'd3,
    CMD_ACCEL   = 4'd4,
    CMD_HALT    = 4'd5,
    CMD_ENABLE  = 4'd6,
    CMD_DISABLE = 4'd7,
    CMD_SETPOS  = 4'd10,
    CMD_ESTOP   = 4'd11
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_ESTOP_REJ  = 3'd1,
    ST_BAD_AXIS   = 3'd2,
    ST_DISABLED   = 3'd3,
    ST_LIMIT      = 3'd4,
    ST_WHEEL_OFF  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ORD_NONE     = 4'd0,
    ORD_MOVE     = 4'd1,
    ORD_SPEED    = 4'd2,
    ORD_ACCEL    = 4'd3,
    ORD_STOP     = 4'd4,
    ORD_ENABLE   = 4'd5,
    ORD_DISABLE  = 4'd6,
    ORD_SETPOS   = 4'd7,
    ORD_STOP_ALL = 4'd8
  } order_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_LOW   = 3'd0,
    REG_X_HIGH  = 3'd1,
    REG_Z_LOW   = 3'd2,
    REG_Z_HIGH  = 3'd3,
    REG_LIM_ON  = 3'd4,
    REG_X_RATIO = 3'd5,
    REG_Z_RATIO = 3'd6,
    REG_WHEEL   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [3:0]              command;
    logic [1:0]              axis_select;
    logic signed [POS_W-1:0] request_value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [3:0]              order_kind;
    logic                    order_axis;
    logic signed [POS_W-1:0] order_value;
    logic signed [POS_W-1:0] axis_position;
  } rsp_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   x_low_limit;
    logic signed [POS_W-1:0]   x_high_limit;
    logic signed [POS_W-1:0]   z_low_limit;
    logic signed [POS_W-1:0]   z_high_limit;
    logic                      limits_on;
    logic signed [RATIO_W-1:0] x_wheel_ratio;
    logic signed [RATIO_W-1:0] z_wheel_ratio;
    logic [1:0]                wheel_enable_mask;
  } cfg_t;

endpackage

>>> rtl/core/soft_limited_axis_command_unit.sv
// ----------------------------------------------------------------------------
// soft_limited_axis_command_unit
// Two-axis motion command unit with soft limits and handwheel scaling.
//
//   channel   direction  handshake              payload
//   cmd       in         cmd_valid / cmd_stall  cmd_data (cmd_t)
//   rsp       out        rsp_valid / rsp_stall  rsp_data (rsp_t)
//   cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// From transfer to result, a command passes through the input register,
// where the handwheel product is formed, then the result register. One
// command per cycle is sustained unless results stall; the multiplier feeding
// the input register and the limit check into the result register set the
// clock. Reset is synchronous and restores limits, ratios, positions and
// flags. A stalled result holds the command in the input register, which
// then stalls the command channel.
// ----------------------------------------------------------------------------
module soft_limited_axis_command_unit
  import slacu_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  cmd_t                   cmd_data,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]       cfg_data
);

  cfg_t                     cfg;
  logic                     out_free;
  logic                     fire;
  cmd_t                     item;
  logic signed [PROD_W-1:0] product;
  rsp_t                     rsp_next;

  slacu_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slacu_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .cfg       (cfg),
    .out_free  (out_free),
    .fire      (fire),
    .item      (item),
    .product   (product)
  );

  slacu_exec #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_exec (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (item),
    .product  (product),
    .cfg      (cfg),
    .rsp_next (rsp_next)
  );

  slacu_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rsp_next  (rsp_next),
    .out_free  (out_free),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

>>> rtl/core/slacu_cfg_regs.sv
// ----------------------------------------------------------------------------
// slacu_cfg_regs
// Configuration register file: soft limits, handwheel ratios and masks.
// ----------------------------------------------------------------------------
module slacu_cfg_regs
  import slacu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]       cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_low_limit       <= LOW_LIMIT_RST;
      cfg.x_high_limit      <= HIGH_LIMIT_RST;
      cfg.z_low_limit       <= LOW_LIMIT_RST;
      cfg.z_high_limit      <= HIGH_LIMIT_RST;
      cfg.limits_on         <= 1'b1;
      cfg.x_wheel_ratio     <= RATIO_RST;
      cfg.z_wheel_ratio     <= RATIO_RST;
      cfg.wheel_enable_mask <= 2'b11;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_X_LOW:   cfg.x_low_limit       <= cfg_data;
        REG_X_HIGH:  cfg.x_high_limit      <= cfg_data;
        REG_Z_LOW:   cfg.z_low_limit       <= cfg_data;
        REG_Z_HIGH:  cfg.z_high_limit      <= cfg_data;
        REG_LIM_ON:  cfg.limits_on         <= cfg_data[0];
        REG_X_RATIO: cfg.x_wheel_ratio     <= cfg_data[RATIO_W-1:0];
        REG_Z_RATIO: cfg.z_wheel_ratio     <= cfg_data[RATIO_W-1:0];
        REG_WHEEL:   cfg.wheel_enable_mask <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/slacu_in_stage.sv
// ----------------------------------------------------------------------------
// slacu_in_stage
// Input register for one command, with the handwheel product registered
// alongside so that the execute stage sees no multiplier.
// ----------------------------------------------------------------------------
module slacu_in_stage
  import slacu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  cmd_t                     cmd_data,
  input  cfg_t                     cfg,
  input  logic                     out_free,
  output logic                     fire,
  output cmd_t                     item,
  output logic signed [PROD_W-1:0] product
);

  logic                      item_valid;
  logic                      load;
  logic signed [RATIO_W-1:0] ratio;

  assign fire      = item_valid && out_free;
  assign cmd_stall = item_valid && !out_free;
  assign load      = cmd_valid && !cmd_stall;
  assign ratio     = cmd_data.axis_select[0] ? cfg.z_wheel_ratio : cfg.x_wheel_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item    <= cmd_data;
      product <= PROD_W'(cmd_data.request_value) * PROD_W'(ratio);
    end
  end

endmodule

>>> rtl/core/slacu_exec.sv
// ----------------------------------------------------------------------------
// slacu_exec
// Command decode, limit check and axis state. Computes the result of the item
// in the input register and updates positions and flags when it moves on.
// ----------------------------------------------------------------------------
module slacu_exec
  import slacu_pkg::*;
#(
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  cmd_t                     item,
  input  logic signed [PROD_W-1:0] product,
  input  cfg_t                     cfg,
  output rsp_t                     rsp_next
);

  localparam logic [PROD_W-1:0] FracMask = (PROD_W'(1) << RATIO_FRAC_BITS) - PROD_W'(1);

  logic [POS_W-1:0] position [2];
  logic [1:0]       enabled;
  logic             estop;

  logic                    ax;
  logic                    sel_ok;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        pos_new;
  logic                    en_new;
  logic                    estop_new;
  logic                    do_move;
  logic                    in_limits;
  logic [POS_W-1:0]        steps;
  logic signed [POS_W:0]   target;
  logic signed [POS_W:0]   lo;
  logic signed [POS_W:0]   hi;
  logic signed [PROD_W-1:0] quot;
  logic                    frac_nz;
  logic                    quot_ovf;
  logic [POS_W-1:0]        wheel_steps;

  assign ax     = item.axis_select[0];
  assign sel_ok = !item.axis_select[1];
  assign pos    = position[ax];
  assign lo     = ax ? {cfg.z_low_limit[POS_W-1], cfg.z_low_limit}
                     : {cfg.x_low_limit[POS_W-1], cfg.x_low_limit};
  assign hi     = ax ? {cfg.z_high_limit[POS_W-1], cfg.z_high_limit}
                     : {cfg.x_high_limit[POS_W-1], cfg.x_high_limit};

  // Handwheel steps: shift down, round a negative quotient toward zero,
  // then clamp to the 32-bit signed range.
  assign frac_nz  = |(product & FracMask);
  assign quot     = (product >>> RATIO_FRAC_BITS)
                    + $signed({{(PROD_W-1){1'b0}}, product[PROD_W-1] && frac_nz});
  assign quot_ovf = !((&quot[PROD_W-1:POS_W-1]) || !(|quot[PROD_W-1:POS_W-1]));
  assign wheel_steps = quot_ovf ? (quot[PROD_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                                  : {1'b0, {(POS_W-1){1'b1}}})
                                : quot[POS_W-1:0];

  assign in_limits = !cfg.limits_on || ((target >= lo) && (target <= hi));

  always_comb begin
    rsp_next  = '0;
    pos_new   = pos;
    en_new    = enabled[ax];
    estop_new = estop;
    do_move   = 1'b0;
    steps     = '0;
    target    = '0;
    if (item.command == CMD_ESTOP) begin
      estop_new = item.request_value[0];
      if (item.request_value[0]) begin
        rsp_next.order_kind = ORD_STOP_ALL;
      end
    end else if (item.command == CMD_SETPOS) begin
      if (!sel_ok) begin
        rsp_next.status = ST_BAD_AXIS;
      end else begin
        pos_new              = item.request_value;
        rsp_next.order_kind  = ORD_SETPOS;
        rsp_next.order_axis  = ax;
        rsp_next.order_value = item.request_value;
      end
    end else if (estop) begin
      rsp_next.status = ST_ESTOP_REJ;
    end else if (!sel_ok) begin
      rsp_next.status = ST_BAD_AXIS;
    end else if (item.command != CMD_ENABLE && !enabled[ax]) begin
      rsp_next.status = ST_DISABLED;
    end else begin
      unique case (item.command)
        CMD_REL: begin
          steps   = item.request_value;
          target  = $signed({pos[POS_W-1], pos})
                    + $signed({item.request_value[POS_W-1], item.request_value});
          do_move = 1'b1;
        end
        CMD_ABS: begin
          steps   = item.request_value - pos;
          target  = {item.request_value[POS_W-1], item.request_value};
          do_move = 1'b1;
        end
        CMD_WHEEL: begin
          if (!cfg.wheel_enable_mask[ax]) begin
            rsp_next.status = ST_WHEEL_OFF;
          end else begin
            steps   = wheel_steps;
            target  = $signed({pos[POS_W-1], pos})
                      + $signed({wheel_steps[POS_W-1], wheel_steps});
            do_move = 1'b1;
          end
        end
        CMD_SPEED: begin
          rsp_next.order_kind  = ORD_SPEED;
          rsp_next.order_axis  = ax;
          rsp_next.order_value = item.request_value;
        end
        CMD_ACCEL: begin
          rsp_next.order_kind  = ORD_ACCEL;
          rsp_next.order_axis  = ax;
          rsp_next.order_value = item.request_value;
        end
        CMD_HALT: begin
          rsp_next.order_kind = ORD_STOP;
          rsp_next.order_axis = ax;
        end
        CMD_ENABLE: begin
          en_new              = 1'b1;
          rsp_next.order_kind = ORD_ENABLE;
          rsp_next.order_axis = ax;
        end
        CMD_DISABLE: begin
          en_new              = 1'b0;
          rsp_next.order_kind = ORD_DISABLE;
          rsp_next.order_axis = ax;
        end
        default: ;
      endcase
      if (do_move) begin
        if (in_limits) begin
          pos_new              = target[POS_W-1:0];
          rsp_next.order_kind  = ORD_MOVE;
          rsp_next.order_axis  = ax;
          rsp_next.order_value = steps;
        end else begin
          rsp_next.status = ST_LIMIT;
        end
      end
    end
    rsp_next.axis_position = sel_ok ? pos_new : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position[0] <= '0;
      position[1] <= '0;
      enabled     <= 2'b11;
      estop       <= 1'b0;
    end else if (fire) begin
      estop <= estop_new;
      if (sel_ok) begin
        position[ax] <= pos_new;
        enabled[ax]  <= en_new;
      end
    end
  end

endmodule

>>> rtl/core/slacu_out_reg.sv
// ----------------------------------------------------------------------------
// slacu_out_reg
// Result register. Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module slacu_out_reg
  import slacu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  rsp_t rsp_next,
  output logic out_free,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  // The register can take a new result when empty or when its transfer
  // completes in this cycle.
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

>>> tb/soft_limited_axis_command_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_limited_axis_command_unit_tb
// Self-checking bench for the two-axis command unit. A tracker class mirrors
// the limits, ratios, positions, enable flags and emergency stop, predicts the
// order and status of every accepted command, and compares each result as it
// leaves the block. Directed commands cover the special cases, then random
// commands run under several register settings with random idling on both
// channels.
// ----------------------------------------------------------------------------
module soft_limited_axis_command_unit_tb;
  import slacu_pkg::*;

  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic [3:0] CMD_NOOP_LO   = 4'd8;
  localparam logic [3:0] CMD_NOOP_HI   = 4'd9;
  localparam logic [3:0] CMD_RSVD_LO   = 4'd12;
  localparam logic [3:0] CMD_RSVD_HI   = 4'd15;
  localparam logic [1:0] AXIS_X        = 2'd0;
  localparam logic [1:0] AXIS_Z        = 2'd1;
  localparam logic [1:0] AXIS_BAD_LO   = 2'd2;
  localparam logic [1:0] AXIS_BAD_HI   = 2'd3;
  localparam int         STALL_LIMIT   = 1000;

  class axis_order_tracker;
    cfg_t                    settings;
    logic signed [POS_W-1:0] position[2];
    bit                      enabled[2];
    bit                      estop_on;
    rsp_t                    expected_orders[$];
    int                      errors;

    function new();
      settings.x_low_limit       = LOW_LIMIT_RST;
      settings.x_high_limit      = HIGH_LIMIT_RST;
      settings.z_low_limit       = LOW_LIMIT_RST;
      settings.z_high_limit      = HIGH_LIMIT_RST;
      settings.limits_on         = 1'b1;
      settings.x_wheel_ratio     = RATIO_RST;
      settings.z_wheel_ratio     = RATIO_RST;
      settings.wheel_enable_mask = 2'b11;
      position[0] = '0;
      position[1] = '0;
      enabled[0]  = 1'b1;
      enabled[1]  = 1'b1;
      estop_on    = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [POS_W-1:0] d);
      case (idx)
        REG_X_LOW:   settings.x_low_limit       = d;
        REG_X_HIGH:  settings.x_high_limit      = d;
        REG_Z_LOW:   settings.z_low_limit       = d;
        REG_Z_HIGH:  settings.z_high_limit      = d;
        REG_LIM_ON:  settings.limits_on         = d[0];
        REG_X_RATIO: settings.x_wheel_ratio     = d[RATIO_W-1:0];
        REG_Z_RATIO: settings.z_wheel_ratio     = d[RATIO_W-1:0];
        REG_WHEEL:   settings.wheel_enable_mask = d[1:0];
        default: ;
      endcase
    endfunction

    // Targets are compared at full width so that an overflowing sum is caught.
    function bit target_allowed(bit ax, longint target);
      longint lo;
      longint hi;
      if (!settings.limits_on) return 1'b1;
      lo = ax ? settings.z_low_limit : settings.x_low_limit;
      hi = ax ? settings.z_high_limit : settings.x_high_limit;
      return target >= lo && target <= hi;
    endfunction

    function void note_command(cmd_t c);
      rsp_t   r;
      bit     ax;
      bit     axis_ok;
      bit     move;
      longint req;
      longint here;
      longint ratio;
      longint steps;
      longint target;
      r       = '0;
      ax      = c.axis_select[0];
      axis_ok = c.axis_select < 2;
      move    = 1'b0;
      req     = c.request_value;
      steps   = 0;
      target  = 0;
      if (c.command == CMD_ESTOP) begin
        estop_on = c.request_value[0];
        if (estop_on) r.order_kind = ORD_STOP_ALL;
      end else if (c.command == CMD_SETPOS) begin
        if (!axis_ok) begin
          r.status = ST_BAD_AXIS;
        end else begin
          position[ax]  = c.request_value;
          r.order_kind  = ORD_SETPOS;
          r.order_axis  = ax;
          r.order_value = c.request_value;
        end
      end else if (estop_on) begin
        r.status = ST_ESTOP_REJ;
      end else if (!axis_ok) begin
        r.status = ST_BAD_AXIS;
      end else if (c.command != CMD_ENABLE && !enabled[ax]) begin
        r.status = ST_DISABLED;
      end else begin
        here = position[ax];
        case (c.command)
          CMD_REL: begin
            steps  = req;
            target = here + req;
            move   = 1'b1;
          end
          CMD_ABS: begin
            target = req;
            steps  = req - here;
            move   = 1'b1;
          end
          CMD_WHEEL: begin
            if (!settings.wheel_enable_mask[ax]) begin
              r.status = ST_WHEEL_OFF;
            end else begin
              ratio = ax ? settings.z_wheel_ratio : settings.x_wheel_ratio;
              // Division of signed integers truncates toward zero.
              steps = (req * ratio) / (longint'(1) <<< RATIO_FRAC_BITS_DEF);
              if (steps > longint'(POS_MAX)) steps = POS_MAX;
              if (steps < longint'(POS_MIN)) steps = POS_MIN;
              target = here + steps;
              move   = 1'b1;
            end
          end
          CMD_SPEED: begin
            r.order_kind  = ORD_SPEED;
            r.order_axis  = ax;
            r.order_value = c.request_value;
          end
          CMD_ACCEL: begin
            r.order_kind  = ORD_ACCEL;
            r.order_axis  = ax;
            r.order_value = c.request_value;
          end
          CMD_HALT: begin
            r.order_kind = ORD_STOP;
            r.order_axis = ax;
          end
          CMD_ENABLE: begin
            enabled[ax]  = 1'b1;
            r.order_kind = ORD_ENABLE;
            r.order_axis = ax;
          end
          CMD_DISABLE: begin
            enabled[ax]  = 1'b0;
            r.order_kind = ORD_DISABLE;
            r.order_axis = ax;
          end
          default: ;
        endcase
        if (move) begin
          if (target_allowed(ax, target)) begin
            position[ax]  = target[POS_W-1:0];
            r.order_kind  = ORD_MOVE;
            r.order_axis  = ax;
            r.order_value = steps[POS_W-1:0];
          end else begin
            r.status = ST_LIMIT;
          end
        end
      end
      r.axis_position = axis_ok ? position[ax] : '0;
      expected_orders.push_back(r);
    endfunction

    function void check_order(rsp_t got);
      rsp_t want;
      if (expected_orders.size() == 0) begin
        $error("result %h arrived with no command pending", got);
        errors++;
        return;
      end
      want = expected_orders.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.order_kind !== want.order_kind) begin
        $error("order_kind: expected %0d, got %0d", want.order_kind, got.order_kind);
        errors++;
      end
      if (got.order_axis !== want.order_axis) begin
        $error("order_axis: expected %0d, got %0d", want.order_axis, got.order_axis);
        errors++;
      end
      if (got.order_value !== want.order_value) begin
        $error("order_value: expected %0d, got %0d", want.order_value, got.order_value);
        errors++;
      end
      if (got.axis_position !== want.axis_position) begin
        $error("axis_position: expected %0d, got %0d",
               want.axis_position, got.axis_position);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_stall;
  cmd_t             cmd_data = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [POS_W-1:0] cfg_data = '0;

  axis_order_tracker tracker = new();
  bit                no_gaps = 1'b0;
  int                quiet_cycles = 0;

  soft_limited_axis_command_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function bit take_gap();
    return !no_gaps && $urandom_range(0, 99) < 23;
  endfunction

  // Result side: check every transfer and stall at random.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_order(rsp_data);
    rsp_stall <= !rst && take_gap();
  end

  // The run ends as failed when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function cmd_t make_cmd(logic [3:0] code, logic [1:0] sel, logic [POS_W-1:0] value);
    make_cmd.command       = code;
    make_cmd.axis_select   = sel;
    make_cmd.request_value = value;
  endfunction

  function logic signed [POS_W-1:0] pick_value(bit pulses);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return POS_MAX;
          1: return POS_MIN;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: begin
        if (pulses) return int'($urandom_range(0, 4000)) - 2000;
        return int'($urandom_range(0, 300000)) - 150000;
      end
    endcase
  endfunction

  // About half the picks are moves, mostly on valid axes, so that positions travel and limits are hit.
  function cmd_t random_command();
    cmd_t c;
    int   pick;
    c.axis_select   = ($urandom_range(0, 99) < 88) ? 2'($urandom_range(0, 1))
                                                    : 2'($urandom_range(2, 3));
    c.request_value = pick_value(1'b0);
    if (tracker.estop_on && $urandom_range(0, 2) != 0) begin
      c.command       = CMD_ESTOP;
      c.request_value = $urandom & 32'hFFFF_FFFE;
      return c;
    end
    pick = $urandom_range(0, 99);
    if (pick < 20) c.command = CMD_REL;
    else if (pick < 35) c.command = CMD_ABS;
    else if (pick < 50) begin
      c.command       = CMD_WHEEL;
      c.request_value = pick_value(1'b1);
    end
    else if (pick < 57) c.command = CMD_SPEED;
    else if (pick < 63) c.command = CMD_ACCEL;
    else if (pick < 68) c.command = CMD_HALT;
    else if (pick < 73) c.command = CMD_ENABLE;
    else if (pick < 77) c.command = CMD_DISABLE;
    else if (pick < 83) c.command = CMD_SETPOS;
    else if (pick < 87) c.command = CMD_ESTOP;
    else if (pick < 90) c.command = 4'($urandom_range(CMD_NOOP_LO, CMD_NOOP_HI));
    else if (pick < 93) c.command = 4'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    else c.command = 4'($urandom_range(0, 15));
    return c;
  endfunction

  // Valid stays high from one transfer to the next unless a gap is taken.
  task automatic send_command(cmd_t c);
    while (take_gap()) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    do @(posedge clk); while (cmd_stall);
    tracker.note_command(c);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_command(random_command());
  endtask

  // Every command yields a result, so an empty queue means the block is idle.
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_orders.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [POS_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, d);
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_X_LOW, c.x_low_limit);
    write_reg(REG_X_HIGH, c.x_high_limit);
    write_reg(REG_Z_LOW, c.z_low_limit);
    write_reg(REG_Z_HIGH, c.z_high_limit);
    write_reg(REG_LIM_ON, {31'd0, c.limits_on});
    write_reg(REG_X_RATIO, {{8{c.x_wheel_ratio[RATIO_W-1]}}, c.x_wheel_ratio});
    write_reg(REG_Z_RATIO, {{8{c.z_wheel_ratio[RATIO_W-1]}}, c.z_wheel_ratio});
    write_reg(REG_WHEEL, {30'd0, c.wheel_enable_mask});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function cfg_t random_config();
    cfg_t c;
    c.x_low_limit  = int'($urandom_range(0, 600000)) - 300000;
    c.x_high_limit = c.x_low_limit + int'($urandom_range(0, 400000));
    c.z_low_limit  = int'($urandom_range(0, 600000)) - 300000;
    c.z_high_limit = c.z_low_limit + int'($urandom_range(0, 400000));
    if ($urandom_range(0, 9) == 0) c.z_high_limit = c.z_low_limit - 1;
    c.limits_on         = $urandom_range(0, 9) != 0;
    c.x_wheel_ratio     = ($urandom_range(0, 3) == 0) ? RATIO_W'($urandom)
                          : RATIO_W'(int'($urandom_range(0, 262144)) - 131072);
    c.z_wheel_ratio     = ($urandom_range(0, 3) == 0) ? RATIO_W'($urandom)
                          : RATIO_W'(int'($urandom_range(0, 262144)) - 131072);
    c.wheel_enable_mask = 2'($urandom_range(0, 3));
    return c;
  endfunction

  initial begin
    cfg_t c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: limits at the edges, the wheel, enable handling, the
    // bad axes and the emergency stop with its exceptions.
    send_command(make_cmd(CMD_REL, AXIS_X, 100000));
    send_command(make_cmd(CMD_REL, AXIS_X, 1));
    send_command(make_cmd(CMD_ABS, AXIS_Z, -100000));
    send_command(make_cmd(CMD_ABS, AXIS_Z, -100001));
    send_command(make_cmd(CMD_WHEEL, AXIS_X, -250));
    send_command(make_cmd(CMD_WHEEL, AXIS_Z, POS_MIN));
    send_command(make_cmd(CMD_SPEED, AXIS_X, POS_MAX));
    send_command(make_cmd(CMD_ACCEL, AXIS_Z, POS_MIN));
    send_command(make_cmd(CMD_HALT, AXIS_X, -1));
    send_command(make_cmd(CMD_DISABLE, AXIS_Z, 7));
    send_command(make_cmd(CMD_REL, AXIS_Z, 5));
    send_command(make_cmd(CMD_WHEEL, AXIS_Z, 5));
    send_command(make_cmd(CMD_ENABLE, AXIS_Z, 0));
    send_command(make_cmd(CMD_NOOP_LO, AXIS_X, 99));
    send_command(make_cmd(CMD_NOOP_HI, AXIS_Z, -99));
    send_command(make_cmd(CMD_RSVD_HI, AXIS_X, POS_MAX));
    send_command(make_cmd(CMD_SPEED, AXIS_BAD_LO, 10));
    send_command(make_cmd(CMD_SETPOS, AXIS_BAD_HI, 10));
    send_command(make_cmd(CMD_ESTOP, AXIS_X, 1));
    send_command(make_cmd(CMD_REL, AXIS_X, 10));
    send_command(make_cmd(CMD_SETPOS, AXIS_Z, 12345));
    send_command(make_cmd(CMD_ESTOP, AXIS_BAD_HI, 3));
    send_command(make_cmd(CMD_ENABLE, AXIS_BAD_HI, 0));
    send_command(make_cmd(CMD_ESTOP, AXIS_Z, -2));
    send_command(make_cmd(CMD_SETPOS, AXIS_X, 0));
    run_random(100);
    wait_idle();

    // Limits off so positions wrap; extreme ratios; second axis wheel masked.
    c.x_low_limit       = POS_MIN;
    c.x_high_limit      = POS_MIN;
    c.z_low_limit       = POS_MAX;
    c.z_high_limit      = POS_MAX;
    c.limits_on         = 1'b0;
    c.x_wheel_ratio     = 24'sh7FFFFF;
    c.z_wheel_ratio     = 24'sh800000;
    c.wheel_enable_mask = 2'b01;
    apply_config(c);
    send_command(make_cmd(CMD_SETPOS, AXIS_X, POS_MAX));
    send_command(make_cmd(CMD_REL, AXIS_X, 10));
    send_command(make_cmd(CMD_WHEEL, AXIS_X, POS_MAX));
    send_command(make_cmd(CMD_WHEEL, AXIS_Z, 3));
    send_command(make_cmd(CMD_ABS, AXIS_Z, POS_MIN));
    run_random(100);
    wait_idle();

    // Full-range limits on the first axis, inverted on the second, and a
    // long stretch with no idling on either side.
    c.x_low_limit       = POS_MIN;
    c.x_high_limit      = POS_MAX;
    c.z_low_limit       = 500;
    c.z_high_limit      = -500;
    c.limits_on         = 1'b1;
    c.x_wheel_ratio     = -24'sd98304;
    c.z_wheel_ratio     = RATIO_RST;
    c.wheel_enable_mask = 2'b10;
    apply_config(c);
    no_gaps = 1'b1;
    send_command(make_cmd(CMD_SETPOS, AXIS_X, POS_MAX - 2));
    send_command(make_cmd(CMD_REL, AXIS_X, 5));
    send_command(make_cmd(CMD_ABS, AXIS_Z, 0));
    send_command(make_cmd(CMD_WHEEL, AXIS_X, 40));
    send_command(make_cmd(CMD_WHEEL, AXIS_Z, 40));
    run_random(100);
    no_gaps = 1'b0;
    wait_idle();

    for (int k = 0; k < 4; k++) begin
      apply_config(random_config());
      run_random(25);
      wait_idle();
    end

    while (tracker.expected_orders.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.expected_orders.size() != 0)
      $error("%0d results never arrived", tracker.expected_orders.size());
    if (tracker.errors == 0 && tracker.expected_orders.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
